// ----- rtl/m4vt_pkg.sv -----
package m4vt_pkg;

    // Vector length and matrix size
    localparam int DIM      = 4;
    localparam int ELEMS    = DIM * DIM;
    localparam int IDX_BITS = 4;

    // Request kinds
    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_XFORM = 1'b1
    } action_t;

    // transpose_mode codes
    typedef enum logic {
        MODE_DIRECT    = 1'b0,
        MODE_TRANSPOSE = 1'b1
    } mode_t;

endpackage

// ----- rtl/m4vt_lane.sv -----
// One lane: multiplies one vector component by the four matrix entries that
// meet it, one per output row. Two stages: split partial products, then
// recombination into full signed products.
module m4vt_lane
    import m4vt_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [WORD_BITS-1:0]       vec_elem,
    input  logic signed [WORD_BITS-1:0]       mat_elem [DIM],
    output logic signed [2*WORD_BITS-1:0]     prod     [DIM]
);

    localparam int LO = WORD_BITS / 2;
    localparam int HI = WORD_BITS - LO;
    localparam int PW = 2 * WORD_BITS;
    localparam int MW = HI + LO + 1;

    // Operand halves: signed high part, unsigned low part
    logic signed [HI-1:0]     vec_hi;
    logic        [LO-1:0]     vec_lo;
    logic signed [HI-1:0]     mat_hi [DIM];
    logic        [LO-1:0]     mat_lo [DIM];

    logic signed [2*HI-1:0]   hh_next [DIM];
    logic signed [MW-1:0]     hl_next [DIM];
    logic signed [MW-1:0]     lh_next [DIM];
    logic        [2*LO-1:0]   ll_next [DIM];

    logic signed [2*HI-1:0]   hh_reg [DIM];
    logic signed [MW-1:0]     hl_reg [DIM];
    logic signed [MW-1:0]     lh_reg [DIM];
    logic        [2*LO-1:0]   ll_reg [DIM];

    logic        [PW-1:0]     prod_next [DIM];
    logic signed [PW-1:0]     prod_reg  [DIM];

    // Partial products
    always_comb
    begin
        vec_hi = vec_elem[WORD_BITS-1:LO];
        vec_lo = vec_elem[LO-1:0];
        for (int i = 0; i < DIM; i++)
        begin
            mat_hi[i]  = mat_elem[i][WORD_BITS-1:LO];
            mat_lo[i]  = mat_elem[i][LO-1:0];
            hh_next[i] = (2*HI)'(mat_hi[i]) * (2*HI)'(vec_hi);
            hl_next[i] = MW'(mat_hi[i]) * $signed({1'b0, vec_lo});
            lh_next[i] = $signed({1'b0, mat_lo[i]}) * MW'(vec_hi);
            ll_next[i] = (2*LO)'(mat_lo[i]) * (2*LO)'(vec_lo);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
        end
    end

    // Recombine halves into full products
    always_comb
    begin
        for (int i = 0; i < DIM; i++)
        begin
            prod_next[i] = (PW'(hh_reg[i]) << (2*LO))
                         + (PW'(hl_reg[i]) << LO)
                         + (PW'(lh_reg[i]) << LO)
                         + PW'(ll_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIM; i++)
            begin
                prod_reg[i] <= $signed(prod_next[i]);
            end
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/m4vt_merge.sv -----
// Merge: sums the lane products per output row, scales by the fraction
// width and saturates. Pair sums are registered, then final add + saturate
// lands in the output register.
module m4vt_merge
    import m4vt_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [2*WORD_BITS-1:0]     prod    [DIM][DIM],
    output logic        [WORD_BITS-1:0]       out_vec [DIM]
);

    localparam int PW = 2 * WORD_BITS;
    localparam int SW = PW + 2;

    localparam logic signed [SW-1:0] MAX_V =
        {{(SW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] MIN_V =
        {{(SW-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

    logic signed [PW:0]          pair_lo_reg [DIM];
    logic signed [PW:0]          pair_hi_reg [DIM];
    logic signed [SW-1:0]        sum     [DIM];
    logic signed [SW-1:0]        scaled  [DIM];
    logic        [WORD_BITS-1:0] out_next [DIM];
    logic        [WORD_BITS-1:0] out_reg  [DIM];

    // Pair sums: lanes 0+1 and 2+3 for each row
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIM; i++)
            begin
                pair_lo_reg[i] <= (PW+1)'(prod[0][i]) + (PW+1)'(prod[1][i]);
                pair_hi_reg[i] <= (PW+1)'(prod[2][i]) + (PW+1)'(prod[3][i]);
            end
        end
    end

    // Final add, arithmetic shift, clamp
    always_comb
    begin
        for (int i = 0; i < DIM; i++)
        begin
            sum[i]    = SW'(pair_lo_reg[i]) + SW'(pair_hi_reg[i]);
            scaled[i] = sum[i] >>> FRAC_BITS;
            if (scaled[i] > MAX_V)
            begin
                out_next[i] = MAX_V[WORD_BITS-1:0];
            end
            else if (scaled[i] < MIN_V)
            begin
                out_next[i] = MIN_V[WORD_BITS-1:0];
            end
            else
            begin
                out_next[i] = scaled[i][WORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_vec = out_reg;

endmodule

// ----- rtl/matrix4_vector_transform_core.sv -----
// Channel  | Handshake             | Payload
// ---------+-----------------------+----------------------------------------
// input    | in_valid / in_stall   | action, element_index, element_value,
//          |                       | vec_x, vec_y, vec_z, vec_w
// output   | out_valid / out_stall | out_x, out_y, out_z, out_w
// config   | cfg_wr_en             | cfg_wr_data (transpose_mode)
//
// One request per clock while in_stall is low. A taken transform request
// passes through capture, partial products, full products, pair sums and
// final add/saturate into the output register. Loads update the matrix at
// the accept edge and give no result. Reset (async, rst_n low) sets the
// matrix to identity and transpose_mode to 0. When the output register holds
// a result and out_stall is high, the whole pipeline freezes and in_stall
// goes high.
module matrix4_vector_transform_core
    import m4vt_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [IDX_BITS-1:0]         element_index,
    input  logic signed [WORD_BITS-1:0] element_value,
    input  logic signed [WORD_BITS-1:0] vec_x,
    input  logic signed [WORD_BITS-1:0] vec_y,
    input  logic signed [WORD_BITS-1:0] vec_z,
    input  logic signed [WORD_BITS-1:0] vec_w,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [WORD_BITS-1:0] out_x,
    output logic signed [WORD_BITS-1:0] out_y,
    output logic signed [WORD_BITS-1:0] out_z,
    output logic signed [WORD_BITS-1:0] out_w
);

    localparam logic [WORD_BITS-1:0] ONE_VAL =
        {{(WORD_BITS-1){1'b0}}, 1'b1} << FRAC_BITS;

    mode_t                        mode_reg;
    logic signed [WORD_BITS-1:0]  mat_reg [ELEMS];

    logic                         advance;
    logic                         accept;
    logic                         is_xform;

    logic                         s0_valid_reg;
    logic                         a_valid_reg;
    logic                         b_valid_reg;
    logic                         c_valid_reg;
    logic                         out_valid_reg;

    logic signed [WORD_BITS-1:0]  vec_in   [DIM];
    logic signed [WORD_BITS-1:0]  vec_reg  [DIM];
    logic signed [WORD_BITS-1:0]  sel_next [DIM][DIM];
    logic signed [WORD_BITS-1:0]  sel_reg  [DIM][DIM];

    logic signed [2*WORD_BITS-1:0] prod [DIM][DIM];
    logic        [WORD_BITS-1:0]   out_vec [DIM];

    // Pipeline moves whenever the output register is free or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;
    assign is_xform = (action_t'(action) == ACT_XFORM);

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DIRECT;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= mode_t'(cfg_wr_data);
        end
    end

    // Matrix store, column-major, identity at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ELEMS; k++)
            begin
                mat_reg[k] <= ((k % (DIM + 1)) == 0) ? ONE_VAL : '0;
            end
        end
        else if (accept && !is_xform)
        begin
            for (int k = 0; k < ELEMS; k++)
            begin
                if (element_index == IDX_BITS'(k))
                begin
                    mat_reg[k] <= element_value;
                end
            end
        end
    end

    // Entry for lane j, row i
    always_comb
    begin
        vec_in[0] = vec_x;
        vec_in[1] = vec_y;
        vec_in[2] = vec_z;
        vec_in[3] = vec_w;
        for (int j = 0; j < DIM; j++)
        begin
            for (int i = 0; i < DIM; i++)
            begin
                sel_next[j][i] = (mode_reg == MODE_TRANSPOSE) ? mat_reg[j + DIM*i]
                                                              : mat_reg[i + DIM*j];
            end
        end
    end

    // Capture stage: vector and selected matrix entries
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vec_reg <= vec_in;
            sel_reg <= sel_next;
        end
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg  <= accept && is_xform;
            a_valid_reg   <= s0_valid_reg;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    // Lanes, one per vector component
    for (genvar j = 0; j < DIM; j++)
    begin : g_lane
        m4vt_lane #(
            .WORD_BITS (WORD_BITS)
        ) u_lane (
            .clk      (clk),
            .en       (advance),
            .vec_elem (vec_reg[j]),
            .mat_elem (sel_reg[j]),
            .prod     (prod[j])
        );
    end

    m4vt_merge #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk     (clk),
        .en      (advance),
        .prod    (prod),
        .out_vec (out_vec)
    );

    assign out_valid = out_valid_reg;
    assign out_x     = $signed(out_vec[0]);
    assign out_y     = $signed(out_vec[1]);
    assign out_z     = $signed(out_vec[2]);
    assign out_w     = $signed(out_vec[3]);

endmodule

// ----- test/matrix4_vector_transform_core_tb.sv -----
module matrix4_vector_transform_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import m4vt_pkg::*;

    localparam int WORD         = 32;
    localparam int FRAC         = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 215;

    typedef logic signed [WORD-1:0] word_t;
    typedef logic [DIM-1:0][WORD-1:0] quad_t;

    localparam logic signed [67:0] SAT_HI = 68'sh7FFF_FFFF;
    localparam logic signed [67:0] SAT_LO = -68'sh8000_0000;

    // Matrix copy, mode copy and the queue of products still owed by the block
    class xform_scoreboard;
        word_t coeffs [ELEMS];
        mode_t transpose;
        quad_t expected_products [$];
        int    errors;
        int    loads;
        int    xforms;
        int    checked;

        function new();
            for (int k = 0; k < ELEMS; k++)
                coeffs[k] = (k % (DIM + 1) == 0) ? word_t'(1 << FRAC) : '0;
            transpose = MODE_DIRECT;
        endfunction

        // Q16.16 matrix-vector product, floored and clamped per component
        function quad_t transform(quad_t vec);
            logic signed [67:0] acc;
            logic signed [67:0] scaled;
            int                 pos;
            quad_t              res;
            for (int i = 0; i < DIM; i++)
            begin
                acc = '0;
                for (int j = 0; j < DIM; j++)
                begin
                    pos = (transpose == MODE_TRANSPOSE) ? (j + DIM * i) : (i + DIM * j);
                    acc = acc + coeffs[pos] * $signed(vec[j]);
                end
                scaled = acc >>> FRAC;
                if (scaled > SAT_HI)
                    res[i] = 32'h7FFF_FFFF;
                else if (scaled < SAT_LO)
                    res[i] = 32'h8000_0000;
                else
                    res[i] = scaled[WORD-1:0];
            end
            return res;
        endfunction

        function void note_request(action_t act, logic [IDX_BITS-1:0] idx, word_t val,
                                   quad_t vec);
            if (act == ACT_LOAD)
            begin
                coeffs[idx] = val;
                loads++;
            end
            else
            begin
                expected_products.push_back(transform(vec));
                xforms++;
            end
        endfunction

        function void check_result(quad_t got);
            quad_t want;
            string names [DIM] = '{"out_x", "out_y", "out_z", "out_w"};
            if (expected_products.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_products.pop_front();
            checked++;
            for (int i = 0; i < DIM; i++)
                if (got[i] !== want[i])
                begin
                    $display("%0t: %s mismatch, expected %h, actual %h",
                             $time, names[i], want[i], got[i]);
                    errors++;
                end
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic                cfg_wr_data   = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic                action        = 1'b0;
    logic [IDX_BITS-1:0] element_index = '0;
    word_t               element_value = '0;
    word_t               vec_x         = '0;
    word_t               vec_y         = '0;
    word_t               vec_z         = '0;
    word_t               vec_w         = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    word_t               out_x;
    word_t               out_y;
    word_t               out_z;
    word_t               out_w;

    xform_scoreboard sb;
    bit              quiet       = 1'b0;
    int              sent_count  = 0;
    int              mode_writes = 0;
    int              hold_left   = 0;

    matrix4_vector_transform_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .element_index (element_index),
        .element_value (element_value),
        .vec_x         (vec_x),
        .vec_y         (vec_y),
        .vec_z         (vec_z),
        .vec_w         (vec_w),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_z         (out_z),
        .out_w         (out_w)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle length: mostly none, sometimes short, rarely long
    function automatic int gap_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Operand mix: rails and unit values, full-range words, small values near zero
    function automatic word_t rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 5))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return '0;
                3:       return '1;
                4:       return 32'h0001_0000;
                default: return 32'hFFFF_0000;
            endcase
        end
        if (r < 5)
            return $urandom();
        return word_t'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endfunction

    function automatic quad_t rand_vec();
        return {rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    // Output side back-pressure
    always @(posedge clk)
    begin
        if (quiet)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            hold_left <= gap_len();
        end
    end

    // Result monitor
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result({out_w, out_z, out_y, out_x});

    // Present one request and hold it until taken
    task automatic send_request(action_t act, logic [IDX_BITS-1:0] idx, word_t val,
                                quad_t vec);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        element_index <= idx;
        element_value <= val;
        vec_x         <= vec[0];
        vec_y         <= vec[1];
        vec_z         <= vec[2];
        vec_w         <= vec[3];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(act, idx, val, vec);
        sent_count++;
    endtask

    task automatic wait_drain();
        while (sb.expected_products.size() != 0)
            @(posedge clk);
    endtask

    // Mode change only with the pipeline empty
    task automatic set_mode(mode_t m);
        in_valid <= 1'b0;
        wait_drain();
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        sb.transpose = m;
        mode_writes++;
    endtask

    // Cycle limit
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("RESULT: ERROR");
        $finish;
    end

    // Main sequence
    initial
    begin
        quad_t vec_edge;
        quad_t vec_max;
        quad_t vec_min;
        quad_t vec_small;
        int    r;
        int    phase_end;

        sb        = new();
        vec_edge  = {32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
        vec_max   = {4{32'h7FFF_FFFF}};
        vec_min   = {4{32'h8000_0000}};
        vec_small = {32'h0000_8000, 32'h0001_0000, 32'hFFFD_8000, 32'h0004_0000};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mode(MODE_DIRECT);

        // identity matrix passes vectors through; element fields ignored
        send_request(ACT_XFORM, 4'hF, 32'h8000_0000, vec_edge);
        send_request(ACT_XFORM, 4'h0, 32'h7FFF_FFFF, vec_small);

        // rail values into the matrix; vector fields ignored on load
        send_request(ACT_LOAD, 4'd0,  32'h7FFF_FFFF, vec_max);
        send_request(ACT_LOAD, 4'd5,  32'h8000_0000, vec_min);
        send_request(ACT_LOAD, 4'd10, 32'h0000_0000, vec_edge);
        send_request(ACT_LOAD, 4'd15, 32'hFFFF_FFFF, vec_small);
        send_request(ACT_LOAD, 4'd4,  32'h7FFF_FFFF, vec_edge);
        send_request(ACT_LOAD, 4'd1,  32'h8000_0000, vec_edge);
        send_request(ACT_LOAD, 4'd3,  32'h0001_8000, vec_edge);

        // positive and negative saturation, plus in-range rows
        send_request(ACT_XFORM, 4'd7, 32'h1234_5678, vec_max);
        send_request(ACT_XFORM, 4'd9, 32'hDEAD_BEEF, vec_min);
        send_request(ACT_XFORM, 4'd2, 32'h0000_0000, vec_edge);
        send_request(ACT_XFORM, 4'd6, 32'hFFFF_FFFF, vec_small);

        // same matrix, transposed product
        set_mode(MODE_TRANSPOSE);
        send_request(ACT_XFORM, 4'd0, 32'h0000_0000, vec_max);
        send_request(ACT_XFORM, 4'd0, 32'h0000_0000, vec_min);
        send_request(ACT_XFORM, 4'd0, 32'h0000_0000, vec_edge);
        send_request(ACT_XFORM, 4'd0, 32'h0000_0000, vec_small);

        // random phases alternating the mode, one with no idling at all
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_mode((ph % 2 == 0) ? MODE_DIRECT : MODE_TRANSPOSE);
            quiet     = (ph == 3);
            phase_end = sent_count + PHASE_ITEMS;
            while (sent_count < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    // whole new matrix, then a burst of transforms
                    for (int k = 0; k < ELEMS; k++)
                        send_request(ACT_LOAD, IDX_BITS'(k), rand_word(), rand_vec());
                    repeat ($urandom_range(2, 6))
                        send_request(ACT_XFORM, IDX_BITS'($urandom_range(0, 15)),
                                     rand_word(), rand_vec());
                end
                else if (r < 10)
                begin
                    // sender holds off until the pipeline is empty
                    in_valid <= 1'b0;
                    wait_drain();
                    @(posedge clk);
                end
                else if (r < 35)
                    send_request(ACT_LOAD, IDX_BITS'($urandom_range(0, 15)),
                                 rand_word(), rand_vec());
                else
                    send_request(ACT_XFORM, IDX_BITS'($urandom_range(0, 15)),
                                 rand_word(), rand_vec());
            end
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        wait_drain();
        repeat (10) @(posedge clk);

        $display("%0d requests (%0d loads, %0d transforms), %0d products checked",
                 sent_count, sb.loads, sb.xforms, sb.checked);
        $display("%0d mode writes across direct and transposed products, %0d errors",
                 mode_writes, sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/m4vt_pkg.sv
rtl/m4vt_lane.sv
rtl/m4vt_merge.sv
rtl/matrix4_vector_transform_core.sv
test/matrix4_vector_transform_core_tb.sv
